>>> rtl/core/lfas_pkg.sv
// Shared types, constants and helpers for the LED frame animation sequencer.
// No dependencies; imported by every module of the block.
package lfas_pkg;

    localparam int DEF_FRAME_SLOTS  = 4;
    localparam int DEF_STRIP_PIXELS = 16;
    localparam int MAX_SLOTS        = 4;
    localparam int MAX_PIXELS       = 16;

    localparam int CMD_W   = 2;
    localparam int SLOT_W  = 2;
    localparam int PIX_W   = 4;
    localparam int TOTAL_W = 5;
    localparam int RGB_W   = 24;
    localparam int TIME_W  = 16;
    localparam int FIU_W   = 3;
    localparam int CFGI_W  = 2;

    localparam logic [CFGI_W-1:0] CFG_FRAMES_IN_USE = 2'd0;
    localparam logic [CFGI_W-1:0] CFG_INSTANT       = 2'd1;
    localparam logic [CFGI_W-1:0] CFG_STOP_COLOR    = 2'd2;

    localparam logic [FIU_W-1:0]  FRAMES_RST     = 3'd1;
    localparam logic              INSTANT_RST    = 1'b1;
    localparam logic [RGB_W-1:0]  STOP_COLOR_RST = 24'h000000;
    localparam logic [TIME_W-1:0] FRAME_TIME_RST = 16'd1;
    localparam logic [TIME_W-1:0] ELAPSED_MAX    = 16'hFFFF;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK   = 2'd0,
        CMD_HEADER = 2'd1,
        CMD_PIXEL  = 2'd2,
        CMD_MASK   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHOW,
        ST_NEXT,
        ST_STOP,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        t_cmd                cmd;
        logic                run;
        logic [SLOT_W-1:0]   frame_slot;
        logic [PIX_W-1:0]    pixel_pos;
        logic [RGB_W-1:0]    pixel_color;
        logic [PIX_W-1:0]    strip_offset;
        logic [TOTAL_W-1:0]  pixel_total;
        logic [TIME_W-1:0]   duration_ticks;
        logic                cleared;
    } t_item;

    typedef struct packed {
        logic [FIU_W-1:0] frames_in_use;
        logic             instant_dispatch;
        logic [RGB_W-1:0] stop_color;
    } t_cfg;

    typedef struct packed {
        logic busy;
        logic rd_pending;
        logic hold_valid;
    } t_status;

    typedef struct packed {
        logic             strobe;
        logic [PIX_W-1:0] strip_pixel;
        logic [RGB_W-1:0] rgb;
        logic             last_write;
    } t_result;

    // v mod d for v <= MAX_SLOTS, d >= 1
    function automatic logic [FIU_W-1:0] mod_small(input logic [FIU_W-1:0] v,
                                                   input logic [FIU_W-1:0] d);
        logic [FIU_W-1:0] r;
        r = v;
        for (int k = 0; k < MAX_SLOTS; k++) begin
            if (r >= d) begin
                r = r - d;
            end
        end
        return r;
    endfunction

endpackage

>>> rtl/core/lfas_pixel_mem.sv
// Frame pixel store: one write port, one registered read port.
// Depends on lfas_pkg.
module lfas_pixel_mem
    import lfas_pkg::*;
#(
    parameter int DEPTH = DEF_FRAME_SLOTS * DEF_STRIP_PIXELS,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [RGB_W-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [RGB_W-1:0] o_rdata
);

    logic [RGB_W-1:0] r_mem [DEPTH];
    logic [RGB_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/lfas_ctrl.sv
// Sequencer control: frame headers, stop mask, tick state machine, read
// stream from the pixel store and result register. Depends on lfas_pkg.
module lfas_ctrl
    import lfas_pkg::*;
#(
    parameter int FRAME_SLOTS  = DEF_FRAME_SLOTS,
    parameter int STRIP_PIXELS = DEF_STRIP_PIXELS,
    parameter int DEPTH        = FRAME_SLOTS * STRIP_PIXELS,
    parameter int AW           = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  t_item            i_item,
    input  t_cfg             i_cfg,
    output logic             o_mem_we,
    output logic [AW-1:0]    o_mem_waddr,
    output logic [RGB_W-1:0] o_mem_wdata,
    output logic             o_mem_re,
    output logic [AW-1:0]    o_mem_raddr,
    input  logic [RGB_W-1:0] i_mem_rdata,
    output t_status          o_status,
    output t_result          o_result
);

    localparam int SLW = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;
    localparam logic [FIU_W-1:0]   FS_N = FIU_W'(FRAME_SLOTS);
    localparam logic [TOTAL_W-1:0] SP_N = TOTAL_W'(STRIP_PIXELS);
    localparam logic [AW-1:0]      SP_A = AW'(STRIP_PIXELS);
    localparam logic [TOTAL_W-1:0] SP_LAST = TOTAL_W'(STRIP_PIXELS - 1);

    function automatic logic [TOTAL_W-1:0] clip_len(input logic [PIX_W-1:0] off,
                                                    input logic [TOTAL_W-1:0] tot);
        logic [TOTAL_W-1:0] room;
        room = SP_N - TOTAL_W'(off);
        if (TOTAL_W'(off) >= SP_N) begin
            return '0;
        end else if (tot > room) begin
            return room;
        end else begin
            return tot;
        end
    endfunction

    t_state r_state, n_state;

    logic                r_started, n_started;
    logic [SLOT_W-1:0]   r_cur, n_cur;
    logic [TIME_W-1:0]   r_elapsed, n_elapsed;
    logic [FIU_W-1:0]    r_budget, n_budget;
    logic                r_first, n_first;
    logic                r_want, n_want;
    logic [TOTAL_W-1:0]  r_idx, n_idx;

    logic [PIX_W-1:0]    r_fstart [FRAME_SLOTS];
    logic [TOTAL_W-1:0]  r_flen   [FRAME_SLOTS];
    logic [TIME_W-1:0]   r_ftime  [FRAME_SLOTS];
    logic [MAX_PIXELS-1:0] r_mask, n_mask;

    logic                r_a_vld, n_a_vld;
    logic [PIX_W-1:0]    r_a_pix, n_a_pix;
    logic                r_a_mem, n_a_mem;

    logic                r_p_vld, n_p_vld;
    logic [PIX_W-1:0]    r_p_pix, n_p_pix;
    logic [RGB_W-1:0]    r_p_rgb, n_p_rgb;

    t_result             r_out, n_out;

    logic                hdr_we;
    logic                rd_en;
    logic [FIU_W-1:0]    count;
    logic [FIU_W-1:0]    next_cur;
    logic [SLW-1:0]      cur_ix;
    logic [SLW-1:0]      hdr_ix;
    logic [TIME_W-1:0]   cur_time;
    logic [TOTAL_W-1:0]  cur_len;
    logic [PIX_W-1:0]    cur_start;
    logic [TIME_W-1:0]   el_inc;
    logic [TOTAL_W-1:0]  item_len;
    logic [TOTAL_W-1:0]  mask_end;
    logic                slot_ok;
    logic                pos_ok;
    logic [RGB_W-1:0]    new_rgb;

    assign count = (i_cfg.frames_in_use == '0) ? FIU_W'(1) :
                   (i_cfg.frames_in_use > FS_N) ? FS_N : i_cfg.frames_in_use;
    assign next_cur  = mod_small(FIU_W'(r_cur) + FIU_W'(1), count);
    assign cur_ix    = r_cur[SLW-1:0];
    assign hdr_ix    = i_item.frame_slot[SLW-1:0];
    assign cur_time  = r_ftime[cur_ix];
    assign cur_len   = r_flen[cur_ix];
    assign cur_start = r_fstart[cur_ix];
    assign el_inc    = (r_elapsed == ELAPSED_MAX) ? r_elapsed : r_elapsed + TIME_W'(1);
    assign item_len  = clip_len(i_item.strip_offset, i_item.pixel_total);
    assign mask_end  = TOTAL_W'(i_item.strip_offset) + item_len;
    assign slot_ok   = FIU_W'(i_item.frame_slot) < FS_N;
    assign pos_ok    = TOTAL_W'(i_item.pixel_pos) < SP_N;
    assign new_rgb   = r_a_mem ? i_mem_rdata : i_cfg.stop_color;

    assign o_mem_we    = (r_state == ST_IDLE) && i_start && (i_item.cmd == CMD_PIXEL)
                         && slot_ok && pos_ok;
    assign o_mem_waddr = AW'(i_item.frame_slot) * SP_A + AW'(i_item.pixel_pos);
    assign o_mem_wdata = i_item.pixel_color;
    assign o_mem_re    = rd_en;
    assign o_mem_raddr = AW'(r_cur) * SP_A + AW'(r_idx[PIX_W-1:0]);

    always_comb begin
        for (int i = 0; i < MAX_PIXELS; i++) begin
            if ((TOTAL_W'(i) >= TOTAL_W'(i_item.strip_offset)) && (TOTAL_W'(i) < mask_end)) begin
                n_mask[i] = i_item.cleared;
            end else begin
                n_mask[i] = r_mask[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_started = r_started;
        n_cur     = r_cur;
        n_elapsed = r_elapsed;
        n_budget  = r_budget;
        n_first   = r_first;
        n_want    = r_want;
        n_idx     = r_idx;
        n_a_vld   = 1'b0;
        n_a_pix   = r_a_pix;
        n_a_mem   = r_a_mem;
        hdr_we    = 1'b0;
        rd_en     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    case (i_item.cmd)
                        CMD_HEADER: begin
                            if (FIU_W'(i_item.frame_slot) < count) begin
                                hdr_we = 1'b1;
                                n_cur  = '0;
                            end
                        end
                        CMD_TICK: begin
                            if (i_item.run) begin
                                if (!r_started) begin
                                    n_started = 1'b1;
                                    n_elapsed = '0;
                                    n_budget  = count - FIU_W'(1);
                                    n_first   = 1'b1;
                                    n_idx     = '0;
                                    n_state   = ST_SHOW;
                                end else if (el_inc >= cur_time) begin
                                    n_elapsed = '0;
                                    n_budget  = count;
                                    n_want    = 1'b1;
                                    n_first   = 1'b0;
                                    n_state   = ST_NEXT;
                                end else begin
                                    n_elapsed = el_inc;
                                end
                            end else if (r_started) begin
                                n_started = 1'b0;
                                n_idx     = '0;
                                n_state   = ST_STOP;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_SHOW: begin
                if (r_idx < cur_len) begin
                    rd_en   = 1'b1;
                    n_a_vld = 1'b1;
                    n_a_pix = cur_start + r_idx[PIX_W-1:0];
                    n_a_mem = 1'b1;
                    n_idx   = r_idx + TOTAL_W'(1);
                end else begin
                    n_want  = r_first ? (cur_time == '0)
                                      : ((cur_time == '0) && i_cfg.instant_dispatch);
                    n_first = 1'b0;
                    n_state = ST_NEXT;
                end
            end
            ST_NEXT: begin
                if (r_want && (r_budget != '0)) begin
                    n_budget = r_budget - FIU_W'(1);
                    n_cur    = next_cur[SLOT_W-1:0];
                    n_idx    = '0;
                    n_state  = ST_SHOW;
                end else begin
                    n_state = ST_FLUSH;
                end
            end
            ST_STOP: begin
                if (r_mask[r_idx[PIX_W-1:0]]) begin
                    n_a_vld = 1'b1;
                    n_a_pix = r_idx[PIX_W-1:0];
                    n_a_mem = 1'b0;
                end
                n_idx = r_idx + TOTAL_W'(1);
                if (r_idx == SP_LAST) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (!r_a_vld) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // one-deep hold so the final write of a command can carry last_write
    always_comb begin
        n_p_vld = r_p_vld;
        n_p_pix = r_p_pix;
        n_p_rgb = r_p_rgb;
        n_out   = r_out;
        n_out.strobe     = 1'b0;
        n_out.last_write = 1'b0;
        if (r_a_vld) begin
            if (r_p_vld) begin
                n_out.strobe      = 1'b1;
                n_out.strip_pixel = r_p_pix;
                n_out.rgb         = r_p_rgb;
            end
            n_p_vld = 1'b1;
            n_p_pix = r_a_pix;
            n_p_rgb = new_rgb;
        end else if ((r_state == ST_FLUSH) && r_p_vld) begin
            n_out.strobe      = 1'b1;
            n_out.strip_pixel = r_p_pix;
            n_out.rgb         = r_p_rgb;
            n_out.last_write  = 1'b1;
            n_p_vld           = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started <= 1'b0;
            r_cur     <= '0;
            r_elapsed <= '0;
            r_budget  <= '0;
            r_first   <= 1'b0;
            r_want    <= 1'b0;
            r_idx     <= '0;
            r_mask    <= '0;
            r_a_vld   <= 1'b0;
            r_p_vld   <= 1'b0;
            r_out     <= '0;
            for (int k = 0; k < FRAME_SLOTS; k++) begin
                r_fstart[k] <= '0;
                r_flen[k]   <= '0;
                r_ftime[k]  <= FRAME_TIME_RST;
            end
        end else begin
            r_started <= n_started;
            r_cur     <= n_cur;
            r_elapsed <= n_elapsed;
            r_budget  <= n_budget;
            r_first   <= n_first;
            r_want    <= n_want;
            r_idx     <= n_idx;
            r_a_vld   <= n_a_vld;
            r_p_vld   <= n_p_vld;
            r_out     <= n_out;
            if ((r_state == ST_IDLE) && i_start && (i_item.cmd == CMD_MASK)) begin
                r_mask <= n_mask;
            end
            if (hdr_we) begin
                r_fstart[hdr_ix] <= i_item.strip_offset;
                r_flen[hdr_ix]   <= item_len;
                r_ftime[hdr_ix]  <= i_item.duration_ticks;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_pix           <= n_a_pix;
        r_a_mem           <= n_a_mem;
        r_p_pix           <= n_p_pix;
        r_p_rgb           <= n_p_rgb;
    end

    assign o_status.busy       = (r_state != ST_IDLE);
    assign o_status.rd_pending = r_a_vld;
    assign o_status.hold_valid = r_p_vld;
    assign o_result            = r_out;

endmodule

>>> rtl/core/led_frame_animation_sequencer.sv
// Top level of the LED frame animation sequencer: ports, configuration
// registers, control and pixel store. Depends on lfas_pkg, lfas_ctrl, lfas_pixel_mem.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+--------------------------------------------
//  command  | i_start / o_busy          | i_cmd i_run i_frame_slot i_pixel_pos ...
//  result   | o_strobe (no back-press.) | o_strip_pixel o_rgb o_last_write
//  config   | i_cfg_valid / o_cfg_ready | i_cfg_index i_cfg_data
//
// Header, pixel and mask commands complete in the cycle they transfer; busy stays low.
// A running tick that starts or advances the animation streams one pixel per cycle
// off the pixel store read port while it shows a frame.
// A stopping tick walks the strip and writes the stop color to masked pixels.
// Synchronous reset; the pixel store has no clearing pass.
// Results are never stalled; each is present for exactly one cycle.
module led_frame_animation_sequencer
    import lfas_pkg::*;
#(
    parameter int FRAME_SLOTS  = DEF_FRAME_SLOTS,
    parameter int STRIP_PIXELS = DEF_STRIP_PIXELS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    output logic                o_busy,
    input  logic [CMD_W-1:0]    i_cmd,
    input  logic                i_run,
    input  logic [SLOT_W-1:0]   i_frame_slot,
    input  logic [PIX_W-1:0]    i_pixel_pos,
    input  logic [RGB_W-1:0]    i_pixel_color,
    input  logic [PIX_W-1:0]    i_strip_offset,
    input  logic [TOTAL_W-1:0]  i_pixel_total,
    input  logic [TIME_W-1:0]   i_duration_ticks,
    input  logic                i_cleared,
    output logic                o_strobe,
    output logic [PIX_W-1:0]    o_strip_pixel,
    output logic [RGB_W-1:0]    o_rgb,
    output logic                o_last_write,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CFGI_W-1:0]   i_cfg_index,
    input  logic [RGB_W-1:0]    i_cfg_data
);

    localparam int DEPTH = FRAME_SLOTS * STRIP_PIXELS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_cfg             r_cfg;
    t_item            w_item;
    t_status          w_status;
    t_result          w_result;
    logic             w_mem_we;
    logic [AW-1:0]    w_mem_waddr;
    logic [RGB_W-1:0] w_mem_wdata;
    logic             w_mem_re;
    logic [AW-1:0]    w_mem_raddr;
    logic [RGB_W-1:0] w_mem_rdata;

    assign w_item.cmd            = t_cmd'(i_cmd);
    assign w_item.run            = i_run;
    assign w_item.frame_slot     = i_frame_slot;
    assign w_item.pixel_pos      = i_pixel_pos;
    assign w_item.pixel_color    = i_pixel_color;
    assign w_item.strip_offset   = i_strip_offset;
    assign w_item.pixel_total    = i_pixel_total;
    assign w_item.duration_ticks = i_duration_ticks;
    assign w_item.cleared        = i_cleared;

    assign o_cfg_ready = !w_status.busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frames_in_use    <= FRAMES_RST;
            r_cfg.instant_dispatch <= INSTANT_RST;
            r_cfg.stop_color       <= STOP_COLOR_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_FRAMES_IN_USE: r_cfg.frames_in_use    <= i_cfg_data[FIU_W-1:0];
                CFG_INSTANT:       r_cfg.instant_dispatch <= i_cfg_data[0];
                CFG_STOP_COLOR:    r_cfg.stop_color       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    lfas_ctrl #(
        .FRAME_SLOTS  (FRAME_SLOTS),
        .STRIP_PIXELS (STRIP_PIXELS),
        .DEPTH        (DEPTH),
        .AW           (AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_item      (w_item),
        .i_cfg       (r_cfg),
        .o_mem_we    (w_mem_we),
        .o_mem_waddr (w_mem_waddr),
        .o_mem_wdata (w_mem_wdata),
        .o_mem_re    (w_mem_re),
        .o_mem_raddr (w_mem_raddr),
        .i_mem_rdata (w_mem_rdata),
        .o_status    (w_status),
        .o_result    (w_result)
    );

    lfas_pixel_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_pixel_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_re    (w_mem_re),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

    assign o_busy        = w_status.busy;
    assign o_strobe      = w_result.strobe;
    assign o_strip_pixel = w_result.strip_pixel;
    assign o_rgb         = w_result.rgb;
    assign o_last_write  = w_result.last_write;

    a_idle_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_status.busy |-> (!w_status.rd_pending && !w_status.hold_valid))
        else $error("idle with a pixel transfer still in flight");

    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(o_busy))
        else $error("result strobe without a command in progress");

    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last_write) |=> !o_strobe)
        else $error("result directly after final write of a command");

endmodule
